FILE: rtl/core/erq_pkg.sv
// erq_pkg: shared types, opcodes and header word layout for the event retransmit queue
// no dependencies
`timescale 1ns / 1ps

package erq_pkg;

  typedef enum logic [1:0] {
    OP_HEADER = 2'd0,
    OP_WORD   = 2'd1,
    OP_PASS   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CP_CHECK,
    ST_CP_DUE,
    ST_CP_HDR,
    ST_CP_RD,
    ST_CP_WR,
    ST_DH_RD,
    ST_DH_SZ,
    ST_DH_MR,
    ST_DH_MW,
    ST_PS_TOP,
    ST_PS_HDR,
    ST_PS_DUE,
    ST_PS_SRD,
    ST_PS_SEM,
    ST_PS_UPD,
    ST_PS_UPD2,
    ST_FIN
  } state_t;

  // entry status codes in the header word
  localparam logic [1:0] STAT_FRESH    = 2'd0;
  localparam logic [1:0] STAT_REPEATED = 2'd1;
  localparam logic [1:0] STAT_DEAD     = 2'd2;

  localparam logic [19:0] REPEAT_DELAY_RST = 20'd20000;
  localparam logic [19:0] EXTRA_DELAY_RST  = 20'd50000;
  localparam int          MAX_RESULTS      = 32;
  localparam int          PEND_DEPTH       = 30;

  typedef enum logic [1:0] {
    REG_REPEAT_DELAY = 2'd0,
    REG_EXTRA_DELAY  = 2'd1
  } reg_index_t;

  // payload words for a byte length
  function automatic logic [5:0] words_of(input logic [6:0] len);
    logic [7:0] s;
    s = {1'b0, len} + 8'd3;
    return s[7:2];
  endfunction

  function automatic logic [6:0] hdr_len(input logic [31:0] h);
    return h[31:25];
  endfunction

  function automatic logic [1:0] hdr_status(input logic [31:0] h);
    return h[8:7];
  endfunction

endpackage

FILE: rtl/core/event_retransmit_queue.sv
// event_retransmit_queue: event send, compacting retransmit store and process passes
// depends on erq_pkg
`timescale 1ns / 1ps

// One request at a time: busy stays high from the accepted start until the cycle in
// which the last result is strobed; configuration is taken only while not busy. A
// payload word that does not finish an event, a header with a payload, or an unknown
// opcode is taken without leaving idle. Finishing an event first drops head entries
// until the new one fits, moving the remaining words down, then writes its due time
// and header and copies each payload word. A pass walks the entries from the head,
// drops or skips dead entries, passes over those not yet due and sends each due one.
// The pace is set by the queue store, which has one read and one write port and
// registered read data, and by the one shared 32-bit adder for every due-time sum
// and the due test. Results are strobed for one cycle each and are never held off;
// last marks the final result of a request.
module event_retransmit_queue #(
  parameter int QUEUE_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [6:0]  service_num,
  input  logic [7:0]  event_id,
  input  logic [6:0]  payload_len,
  input  logic [31:0] data_word,
  input  logic [31:0] now,
  input  logic [4:0]  send_budget,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  output logic        result_valid,
  output logic [6:0]  out_service,
  output logic [7:0]  out_counter,
  output logic [7:0]  out_event,
  output logic [6:0]  out_length,
  output logic [4:0]  word_index,
  output logic [31:0] out_word,
  output logic [1:0]  send_number,
  output logic        end_of_send,
  output logic        last
);
  import erq_pkg::*;

  localparam int QW = QUEUE_BYTES / 4;
  localparam int AW = $clog2(QW);
  localparam int FW = $clog2(QW + 1);
  localparam int SW = FW + 3;
  localparam int MAX_LEN = (QW * 4 - 8 < 120) ? (QW * 4 - 8) : 120;

  state_t state, state_next;

  logic [31:0] store [QW];
  logic [31:0] pend_mem [PEND_DEPTH];
  logic [31:0] rdata, prdata;
  logic [SW-1:0] raddr;
  logic [4:0] praddr;
  logic          we;
  logic [SW-1:0] waddr;
  logic [31:0]   wdata;

  logic [FW-1:0] fill, fill_next, pos, pos_next, mv_i, mv_i_next;
  logic [7:0]  counter, counter_next;
  logic        pend_valid, pend_valid_next;
  logic [6:0]  pend_service, pend_len;
  logic [7:0]  pend_event;
  logic [31:0] pend_now, now_r;
  logic [4:0]  pend_words, pend_words_next;
  logic [31:0] cur_hdr, cur_hdr_next, cur_due, cur_due_next;
  logic [4:0]  budget, budget_next, k, k_next;
  logic [5:0]  n_res, n_res_next;
  logic [6:0]  dh_sz, dh_sz_next;
  logic        ret_pass, ret_pass_next;
  logic [19:0] repeat_delay, extra_delay;

  logic        emit_en;
  logic [4:0]  emit_widx;
  logic [31:0] emit_word;
  logic [1:0]  emit_sn;
  logic        emit_eos;
  logic        h_valid;
  logic [31:0] h_hdr, h_word;
  logic [4:0]  h_widx;
  logic [1:0]  h_sn;
  logic        h_eos;

  logic [31:0] add_a, add_b, add_sum;
  logic        add_sub;

  logic [SW-1:0] fill_x, pos_x, mv_x;
  logic [5:0]    cur_w, rd_w, pend_w;
  logic [SW-1:0] cur_sz, rd_sz, need;
  logic [1:0]    cur_st;
  logic [5:0]    cnt;
  logic [6:0]    n_plus;
  logic [6:0]    hdr_len_cap;
  logic          is_due, k_last;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = ~busy;

  assign fill_x = SW'(fill);
  assign pos_x  = SW'(pos);
  assign mv_x   = SW'(mv_i);
  assign cur_w  = words_of(hdr_len(cur_hdr));
  assign rd_w   = words_of(hdr_len(rdata));
  assign pend_w = words_of(pend_len);
  assign cur_sz = SW'(cur_w) + SW'(2);
  assign rd_sz  = SW'(rd_w) + SW'(2);
  assign need   = SW'(pend_w) + SW'(2);
  assign cur_st = hdr_status(cur_hdr);
  assign cnt    = (cur_w == 6'd0) ? 6'd1 : cur_w;
  assign n_plus = {1'b0, n_res} + {1'b0, cnt};
  assign is_due = ~add_sum[31];
  assign k_last = ({1'b0, k} + 6'd1 == cur_w);
  assign hdr_len_cap = (payload_len > 7'(MAX_LEN)) ? 7'(MAX_LEN) : payload_len;

  // shared adder
  always_comb begin
    add_a   = pend_now;
    add_b   = {12'd0, repeat_delay};
    add_sub = 1'b0;
    case (state)
      ST_PS_DUE: begin
        add_a   = now_r;
        add_b   = rdata;
        add_sub = 1'b1;
      end
      ST_PS_UPD: begin
        add_a = cur_due;
        add_b = {12'd0, extra_delay};
      end
      default: begin
        add_a = pend_now;
      end
    endcase
  end
  assign add_sum = add_a + (add_sub ? ~add_b : add_b) + {31'd0, add_sub};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (opcode_t'(opcode))
            OP_HEADER: if (hdr_len_cap == 7'd0) state_next = ST_CP_CHECK;
            OP_WORD: begin
              if (pend_valid && {1'b0, pend_words} < pend_w &&
                  {1'b0, pend_words} + 6'd1 == pend_w)
                state_next = ST_CP_CHECK;
            end
            OP_PASS: state_next = ST_PS_TOP;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_CP_CHECK: begin
        if (fill != '0 && SW'(QW) - fill_x < need) state_next = ST_DH_RD;
        else state_next = ST_CP_DUE;
      end
      ST_CP_DUE: state_next = ST_CP_HDR;
      ST_CP_HDR: state_next = (cur_w == 6'd0) ? ST_FIN : ST_CP_RD;
      ST_CP_RD:  state_next = ST_CP_WR;
      ST_CP_WR:  state_next = k_last ? ST_FIN : ST_CP_RD;
      ST_DH_RD: begin
        if (fill_x < SW'(2)) state_next = ret_pass ? ST_PS_TOP : ST_CP_CHECK;
        else state_next = ST_DH_SZ;
      end
      ST_DH_SZ: begin
        if (rd_sz >= fill_x) state_next = ret_pass ? ST_PS_TOP : ST_CP_CHECK;
        else state_next = ST_DH_MR;
      end
      ST_DH_MR: state_next = ST_DH_MW;
      ST_DH_MW: begin
        if (mv_x + SW'(1) == fill_x - SW'(dh_sz))
          state_next = ret_pass ? ST_PS_TOP : ST_CP_CHECK;
        else state_next = ST_DH_MR;
      end
      ST_PS_TOP: state_next = (pos_x + SW'(1) < fill_x) ? ST_PS_HDR : ST_FIN;
      ST_PS_HDR: begin
        if (pos_x + rd_sz > fill_x) state_next = ST_FIN;
        else if (hdr_status(rdata) >= STAT_DEAD)
          state_next = (pos == '0) ? ST_DH_RD : ST_PS_TOP;
        else state_next = ST_PS_DUE;
      end
      ST_PS_DUE: begin
        if (!is_due) state_next = ST_PS_TOP;
        else if (budget == 5'd0 || n_plus > 7'(MAX_RESULTS)) state_next = ST_FIN;
        else state_next = (cur_w == 6'd0) ? ST_PS_UPD : ST_PS_SRD;
      end
      ST_PS_SRD: state_next = ST_PS_SEM;
      ST_PS_SEM: state_next = k_last ? ST_PS_UPD : ST_PS_SRD;
      ST_PS_UPD: begin
        if (cur_st == STAT_REPEATED) state_next = (pos == '0) ? ST_DH_RD : ST_PS_TOP;
        else state_next = ST_PS_UPD2;
      end
      ST_PS_UPD2: state_next = ST_PS_TOP;
      ST_FIN:     state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    fill_next       = fill;
    pos_next        = pos;
    mv_i_next       = mv_i;
    counter_next    = counter;
    pend_valid_next = pend_valid;
    pend_words_next = pend_words;
    cur_hdr_next    = cur_hdr;
    cur_due_next    = cur_due;
    budget_next     = budget;
    k_next          = k;
    n_res_next      = n_res;
    dh_sz_next      = dh_sz;
    ret_pass_next   = ret_pass;
    raddr           = pos_x;
    praddr          = k;
    we              = 1'b0;
    waddr           = fill_x;
    wdata           = add_sum;
    emit_en         = 1'b0;
    emit_widx       = k;
    emit_word       = 32'd0;
    emit_sn         = 2'd0;
    emit_eos        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (opcode_t'(opcode))
            OP_HEADER: begin
              pend_valid_next = 1'b1;
              pend_words_next = 5'd0;
              if (hdr_len_cap == 7'd0) begin
                counter_next    = counter + 8'd1;
                cur_hdr_next    = {7'd0, counter + 8'd1, event_id, STAT_FRESH,
                                   service_num};
                pend_valid_next = 1'b0;
                ret_pass_next   = 1'b0;
              end
            end
            OP_WORD: begin
              if (pend_valid && {1'b0, pend_words} < pend_w) begin
                pend_words_next = pend_words + 5'd1;
                if ({1'b0, pend_words} + 6'd1 == pend_w) begin
                  counter_next    = counter + 8'd1;
                  cur_hdr_next    = {pend_len, counter + 8'd1, pend_event, STAT_FRESH,
                                     pend_service};
                  pend_valid_next = 1'b0;
                  pend_words_next = 5'd0;
                  ret_pass_next   = 1'b0;
                end
              end
            end
            OP_PASS: begin
              pos_next      = '0;
              n_res_next    = 6'd0;
              budget_next   = send_budget;
              ret_pass_next = 1'b1;
            end
            default: begin
              pos_next = pos;
            end
          endcase
        end
      end
      ST_CP_DUE: begin
        we    = 1'b1;
        waddr = fill_x;
        wdata = add_sum;
      end
      ST_CP_HDR: begin
        we    = 1'b1;
        waddr = fill_x + SW'(1);
        wdata = cur_hdr;
        k_next = 5'd0;
        if (cur_w == 6'd0) begin
          emit_en   = 1'b1;
          emit_widx = 5'd0;
          emit_eos  = 1'b1;
          fill_next = fill + FW'(2);
        end
      end
      ST_CP_RD: praddr = k;
      ST_CP_WR: begin
        emit_en   = 1'b1;
        emit_word = prdata;
        emit_eos  = k_last;
        we        = 1'b1;
        waddr     = fill_x + SW'(2) + SW'(k);
        wdata     = prdata;
        k_next    = k + 5'd1;
        if (k_last) fill_next = FW'(fill_x + need);
      end
      ST_DH_RD: begin
        raddr = SW'(1);
        if (fill_x < SW'(2)) fill_next = '0;
      end
      ST_DH_SZ: begin
        dh_sz_next = rd_sz[6:0];
        mv_i_next  = '0;
        if (rd_sz >= fill_x) fill_next = '0;
      end
      ST_DH_MR: raddr = mv_x + SW'(dh_sz);
      ST_DH_MW: begin
        we        = 1'b1;
        waddr     = mv_x;
        wdata     = rdata;
        mv_i_next = mv_i + FW'(1);
        if (mv_x + SW'(1) == fill_x - SW'(dh_sz)) fill_next = FW'(fill_x - SW'(dh_sz));
      end
      ST_PS_TOP: raddr = pos_x + SW'(1);
      ST_PS_HDR: begin
        cur_hdr_next = rdata;
        raddr        = pos_x;
        if (!(pos_x + rd_sz > fill_x) && hdr_status(rdata) >= STAT_DEAD && pos != '0)
          pos_next = FW'(pos_x + rd_sz);
      end
      ST_PS_DUE: begin
        cur_due_next = rdata;
        k_next       = 5'd0;
        if (!is_due) pos_next = FW'(pos_x + cur_sz);
        else if (!(budget == 5'd0 || n_plus > 7'(MAX_RESULTS))) begin
          budget_next = budget - 5'd1;
          if (cur_w == 6'd0) begin
            emit_en    = 1'b1;
            emit_widx  = 5'd0;
            emit_eos   = 1'b1;
            emit_sn    = cur_st + 2'd1;
            n_res_next = n_res + 6'd1;
          end
        end
      end
      ST_PS_SRD: raddr = pos_x + SW'(2) + SW'(k);
      ST_PS_SEM: begin
        emit_en    = 1'b1;
        emit_word  = rdata;
        emit_eos   = k_last;
        emit_sn    = cur_st + 2'd1;
        n_res_next = n_res + 6'd1;
        k_next     = k + 5'd1;
      end
      ST_PS_UPD: begin
        if (cur_st == STAT_REPEATED) begin
          if (pos != '0) begin
            we       = 1'b1;
            waddr    = pos_x + SW'(1);
            wdata    = {cur_hdr[31:9], STAT_DEAD, cur_hdr[6:0]};
            pos_next = FW'(pos_x + cur_sz);
          end
        end else begin
          we    = 1'b1;
          waddr = pos_x;
          wdata = add_sum;
        end
      end
      ST_PS_UPD2: begin
        we       = 1'b1;
        waddr    = pos_x + SW'(1);
        wdata    = {cur_hdr[31:9], STAT_REPEATED, cur_hdr[6:0]};
        pos_next = FW'(pos_x + cur_sz);
      end
      default: begin
        raddr = pos_x;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) store[waddr[AW-1:0]] <= wdata;
    rdata <= store[raddr[AW-1:0]];
    if (state == ST_IDLE && start && opcode_t'(opcode) == OP_WORD && pend_valid &&
        {1'b0, pend_words} < pend_w)
      pend_mem[pend_words] <= data_word;
    prdata <= pend_mem[praddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fill         <= '0;
      pos          <= '0;
      mv_i         <= '0;
      counter      <= 8'd0;
      pend_valid   <= 1'b0;
      pend_words   <= 5'd0;
      budget       <= 5'd0;
      k            <= 5'd0;
      n_res        <= 6'd0;
      dh_sz        <= 7'd0;
      ret_pass     <= 1'b0;
      repeat_delay <= REPEAT_DELAY_RST;
      extra_delay  <= EXTRA_DELAY_RST;
      h_valid      <= 1'b0;
      result_valid <= 1'b0;
      pend_service <= 7'd0;
      pend_event   <= 8'd0;
      pend_len     <= 7'd0;
      pend_now     <= 32'd0;
    end else begin
      state      <= state_next;
      fill       <= fill_next;
      pos        <= pos_next;
      mv_i       <= mv_i_next;
      counter    <= counter_next;
      pend_valid <= pend_valid_next;
      pend_words <= pend_words_next;
      budget     <= budget_next;
      k          <= k_next;
      n_res      <= n_res_next;
      dh_sz      <= dh_sz_next;
      ret_pass   <= ret_pass_next;
      if (cfg_valid && cfg_ready) begin
        case (reg_index_t'(cfg_index))
          REG_REPEAT_DELAY: repeat_delay <= cfg_data;
          REG_EXTRA_DELAY:  extra_delay  <= cfg_data;
          default: begin
            repeat_delay <= repeat_delay;
          end
        endcase
      end
      if (state == ST_IDLE && start && opcode_t'(opcode) == OP_HEADER) begin
        pend_service <= service_num;
        pend_event   <= event_id;
        pend_len     <= hdr_len_cap;
        pend_now     <= now;
      end
      result_valid <= 1'b0;
      if (emit_en) begin
        h_valid      <= 1'b1;
        result_valid <= h_valid;
      end else if (state == ST_FIN) begin
        h_valid      <= 1'b0;
        result_valid <= h_valid;
      end
    end
  end

  // current entry, pass time, held result and output registers
  always_ff @(posedge clk) begin
    cur_hdr <= cur_hdr_next;
    cur_due <= cur_due_next;
    if (state == ST_IDLE && start && opcode_t'(opcode) == OP_PASS) now_r <= now;
    if (emit_en) begin
      h_hdr  <= cur_hdr;
      h_widx <= emit_widx;
      h_word <= emit_word;
      h_sn   <= emit_sn;
      h_eos  <= emit_eos;
    end
    if ((emit_en || state == ST_FIN) && h_valid) begin
      out_service <= h_hdr[6:0];
      out_counter <= h_hdr[24:17];
      out_event   <= h_hdr[16:9];
      out_length  <= h_hdr[31:25];
      word_index  <= h_widx;
      out_word    <= h_word;
      send_number <= h_sn;
      end_of_send <= h_eos;
      last        <= (state == ST_FIN);
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) SW'(fill) <= SW'(QW))
    else $error("fill beyond store");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |-> state == ST_IDLE)
    else $error("last result while still working");
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !h_valid)
    else $error("held result left at idle");
  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pend_words <= 5'(PEND_DEPTH))
    else $error("pending word count too large");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    n_res <= 6'(MAX_RESULTS))
    else $error("result count over limit");

endmodule
